### src/tcce_pkg.sv
package tcce_pkg;

    localparam int MAX_COLUMNS = 80;
    localparam int MAX_ROWS    = 25;
    localparam int CELLS       = MAX_COLUMNS * MAX_ROWS;

    // field widths of the request and response channels
    localparam int COL_W      = 7;
    localparam int ROW_W      = 5;
    localparam int ADDR_W     = 11;
    localparam int CHAR_W     = 8;
    localparam int CELL_W     = 16;
    localparam int TAB_W      = 5;
    localparam int COLOR_W    = 4;

    // cell store addressing
    localparam int MEM_AW     = $clog2(CELLS);
    localparam int CNT_W      = $clog2(CELLS + 1);

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 7;

    localparam logic [CFG_IDX_W-1:0] REG_COLUMNS       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ROWS          = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TEXT_COLOR    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_FILL_COLOR    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_TAB_SIZE      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_CURSOR_ENABLE = 3'd5;

    localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;
    localparam logic [CHAR_W-1:0] CH_BEL   = 8'h07;
    localparam logic [CHAR_W-1:0] CH_BS    = 8'h08;
    localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
    localparam logic [CHAR_W-1:0] CH_LF    = 8'h0a;
    localparam logic [CHAR_W-1:0] CH_VT    = 8'h0b;
    localparam logic [CHAR_W-1:0] CH_FF    = 8'h0c;
    localparam logic [CHAR_W-1:0] CH_CR    = 8'h0d;
    localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;

    localparam logic [CELL_W-1:0] BLANK_CELL = 16'h0720;

    typedef enum logic [2:0] {
        CLS_READ,
        CLS_ZERO,
        CLS_NOP,
        CLS_NL,
        CLS_CR,
        CLS_TAB,
        CLS_VT,
        CLS_PRINT
    } cls_t;

    typedef struct packed {
        cls_t              cls;
        logic [CHAR_W-1:0] char_code;
        logic [ADDR_W-1:0] cell_address;
    } cmd_t;

    typedef struct packed {
        logic [COL_W-1:0]   cols;
        logic [ROW_W-1:0]   rows;
        logic [2*COLOR_W-1:0] attr;
        logic [TAB_W-1:0]   tab;
        logic               cursor_en;
    } cfg_t;

endpackage

### src/tcce_if.sv
interface tcce_req_if;
    import tcce_pkg::*;

    logic              valid;
    logic              ready;
    logic              req_type;
    logic [CHAR_W-1:0] char_code;
    logic [ADDR_W-1:0] cell_address;

    modport source (output valid, req_type, char_code, cell_address, input ready);
    modport sink   (input valid, req_type, char_code, cell_address, output ready);
endinterface

interface tcce_rsp_if;
    import tcce_pkg::*;

    logic              valid;
    logic              ready;
    logic [ADDR_W-1:0] cursor_offset;
    logic [COL_W-1:0]  cursor_column;
    logic [ROW_W-1:0]  cursor_row;
    logic              cursor_update;
    logic              scrolled;
    logic              accepted;
    logic [CHAR_W-1:0] cell_char;
    logic [CHAR_W-1:0] cell_attr;

    modport source (output valid, cursor_offset, cursor_column, cursor_row, cursor_update,
                    scrolled, accepted, cell_char, cell_attr, input ready);
    modport sink   (input valid, cursor_offset, cursor_column, cursor_row, cursor_update,
                    scrolled, accepted, cell_char, cell_attr, output ready);
endinterface

### src/text_console_character_engine.sv
// Text console engine: a 80x25 store of 16-bit cells (char low byte, attribute high byte)
// with a cursor; put requests print or interpret one byte, read requests return one cell,
// and every request yields exactly one response. After reset the store is cleared to
// gray-on-black spaces in a pass during which req.ready stays low
// (configuration writes are taken throughout). A two-entry request queue sits in front
// of the execute unit and a response register after it. Reads and puts that do not
// scroll execute against the cell store in RUN and form the response in REPORT,
// which waits while an older response is stalled; the execute unit takes the next
// request after that. A put that scrolls walks the in-use area one cell per cycle,
// reading via the read port and writing via the write port. The user must write
// configuration only while no request is in flight; the block does not enforce this.
module text_console_character_engine (
    input  logic                             clk,
    input  logic                             rst_n,
    tcce_req_if.sink                         req,
    tcce_rsp_if.source                       rsp,
    input  logic                             cfg_we,
    input  logic [tcce_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [tcce_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import tcce_pkg::*;

    cfg_t cfg;
    cmd_t q_cmd;
    logic q_valid;
    logic q_ready;
    logic clearing;

    tcce_regs u_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    tcce_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .hold    (clearing),
        .req     (req),
        .q_valid (q_valid),
        .q_ready (q_ready),
        .q_cmd   (q_cmd)
    );

    tcce_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .q_valid  (q_valid),
        .q_ready  (q_ready),
        .q_cmd    (q_cmd),
        .clearing (clearing),
        .rsp      (rsp)
    );

endmodule

### src/tcce_regs.sv
module tcce_regs (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [tcce_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [tcce_pkg::CFG_DATA_W-1:0]  cfg_data,
    output tcce_pkg::cfg_t                   cfg
);
    import tcce_pkg::*;

    logic [COL_W-1:0]   columns_reg;
    logic [ROW_W-1:0]   rows_reg;
    logic [COLOR_W-1:0] text_color_reg;
    logic [COLOR_W-1:0] fill_color_reg;
    logic [TAB_W-1:0]   tab_size_reg;
    logic               cursor_enable_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            columns_reg       <= COL_W'(MAX_COLUMNS);
            rows_reg          <= ROW_W'(MAX_ROWS);
            text_color_reg    <= 4'd7;
            fill_color_reg    <= 4'd0;
            tab_size_reg      <= 5'd8;
            cursor_enable_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_COLUMNS:       columns_reg       <= cfg_data[COL_W-1:0];
                REG_ROWS:          rows_reg          <= cfg_data[ROW_W-1:0];
                REG_TEXT_COLOR:    text_color_reg    <= cfg_data[COLOR_W-1:0];
                REG_FILL_COLOR:    fill_color_reg    <= cfg_data[COLOR_W-1:0];
                REG_TAB_SIZE:      tab_size_reg      <= cfg_data[TAB_W-1:0];
                REG_CURSOR_ENABLE: cursor_enable_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // oversized geometry clamps to the store size
    always_comb
    begin
        cfg.cols      = (columns_reg > COL_W'(MAX_COLUMNS)) ? COL_W'(MAX_COLUMNS) : columns_reg;
        cfg.rows      = (rows_reg > ROW_W'(MAX_ROWS)) ? ROW_W'(MAX_ROWS) : rows_reg;
        cfg.attr      = {fill_color_reg, text_color_reg};
        cfg.tab       = tab_size_reg;
        cfg.cursor_en = cursor_enable_reg;
    end

endmodule

### src/tcce_front.sv
module tcce_front (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            hold,
    tcce_req_if.sink        req,
    output logic            q_valid,
    input  logic            q_ready,
    output tcce_pkg::cmd_t  q_cmd
);
    import tcce_pkg::*;

    localparam int QDEPTH = 2;
    localparam int PTR_W  = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    cmd_t              entry_reg [QDEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;
    logic              push, pop;
    cmd_t              new_cmd;

    always_comb
    begin
        new_cmd.char_code    = req.char_code;
        new_cmd.cell_address = req.cell_address;
        if (req.req_type)
        begin
            new_cmd.cls = CLS_READ;
        end
        else
        begin
            case (req.char_code)
                CH_NUL:               new_cmd.cls = CLS_ZERO;
                CH_BEL, CH_BS, CH_FF: new_cmd.cls = CLS_NOP;
                CH_LF:                new_cmd.cls = CLS_NL;
                CH_CR:                new_cmd.cls = CLS_CR;
                CH_TAB:               new_cmd.cls = CLS_TAB;
                CH_VT:                new_cmd.cls = CLS_VT;
                default:              new_cmd.cls = CLS_PRINT;
            endcase
        end
    end

    assign req.ready = !hold && (count_reg != QCNT_W'(QDEPTH));
    assign push      = req.valid && req.ready;
    assign q_valid   = (count_reg != '0);
    assign pop       = q_valid && q_ready;
    assign q_cmd     = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + QCNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= new_cmd;
        end
    end

endmodule

### src/tcce_back.sv
module tcce_back (
    input  logic            clk,
    input  logic            rst_n,
    input  tcce_pkg::cfg_t  cfg,
    input  logic            q_valid,
    output logic            q_ready,
    input  tcce_pkg::cmd_t  q_cmd,
    output logic            clearing,
    tcce_rsp_if.source      rsp
);
    import tcce_pkg::*;

    typedef enum logic [3:0] {
        ST_CLEAR  = 4'b0001,
        ST_RUN    = 4'b0010,
        ST_SCROLL = 4'b0100,
        ST_REPORT = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    logic [COL_W-1:0]  col_reg, col_next;
    logic [ROW_W-1:0]  row_reg, row_next;
    logic [MEM_AW-1:0] clr_reg, clr_next;
    logic [CNT_W-1:0]  ptr_reg, ptr_next;
    logic [CNT_W-1:0]  total_reg, total_next;
    logic [CNT_W-1:0]  copy_end_reg, copy_end_next;
    logic              pend_valid_reg, pend_valid_next;
    logic [MEM_AW-1:0] pend_addr_reg, pend_addr_next;
    logic              pend_copy_reg, pend_copy_next;

    logic res_read_reg, res_read_next;
    logic res_upd_reg, res_upd_next;
    logic res_scr_reg, res_scr_next;
    logic res_acc_reg, res_acc_next;
    logic res_oob_reg, res_oob_next;

    logic              out_valid_reg, out_valid_next;
    logic [ADDR_W-1:0] out_offset_reg;
    logic [COL_W-1:0]  out_col_reg;
    logic [ROW_W-1:0]  out_row_reg;
    logic              out_upd_reg, out_scr_reg, out_acc_reg;
    logic [CHAR_W-1:0] out_char_reg, out_attr_reg;
    logic              out_load;

    logic [CELL_W-1:0] mem [CELLS];
    logic [CELL_W-1:0] rd_data_reg;
    logic              mem_we, mem_re;
    logic [MEM_AW-1:0] mem_waddr, mem_raddr;
    logic [CELL_W-1:0] mem_wdata;

    logic [COL_W-1:0]       nc;
    logic [ROW_W-1:0]       nr;
    logic [ROW_W+COL_W-1:0] cur_off;
    logic [ROW_W+COL_W-1:0] area;
    logic                   in_screen, at_end, nl_scroll, tab_past, do_nl;
    logic [ROW_W-1:0]       nl_row;
    logic [7:0]             tab_ext, tab_col;
    logic [CELL_W-1:0]      fill_cell;

    assign nc        = cfg.cols;
    assign nr        = cfg.rows;
    assign cur_off   = ({{COL_W{1'b0}}, row_reg} * {{ROW_W{1'b0}}, nc})
                     + {{ROW_W{1'b0}}, col_reg};
    assign area      = {{COL_W{1'b0}}, nr} * {{ROW_W{1'b0}}, nc};
    assign in_screen = (col_reg < nc) && (row_reg < nr);
    assign at_end    = col_reg >= nc - COL_W'(1);
    assign nl_scroll = row_reg >= nr - ROW_W'(1);
    assign nl_row    = nl_scroll ? nr - ROW_W'(1) : row_reg + ROW_W'(1);
    assign tab_ext   = {3'b000, cfg.tab};
    assign tab_col   = ({1'b0, col_reg} + tab_ext) & ~(tab_ext - 8'd1);
    assign tab_past  = tab_col >= {1'b0, nc};
    assign fill_cell = {cfg.attr, CH_SPACE};
    assign clearing  = (state_reg == ST_CLEAR);
    assign q_ready   = (state_reg == ST_RUN);
    assign out_load  = (state_reg == ST_REPORT) && (!out_valid_reg || rsp.ready);

    always_comb
    begin
        state_next      = state_reg;
        col_next        = col_reg;
        row_next        = row_reg;
        clr_next        = clr_reg;
        ptr_next        = ptr_reg;
        total_next      = total_reg;
        copy_end_next   = copy_end_reg;
        pend_valid_next = pend_valid_reg;
        pend_addr_next  = pend_addr_reg;
        pend_copy_next  = pend_copy_reg;
        res_read_next   = res_read_reg;
        res_upd_next    = res_upd_reg;
        res_scr_next    = res_scr_reg;
        res_acc_next    = res_acc_reg;
        res_oob_next    = res_oob_reg;
        mem_we          = 1'b0;
        mem_waddr       = cur_off[MEM_AW-1:0];
        mem_wdata       = {cfg.attr, q_cmd.char_code};
        mem_re          = 1'b0;
        mem_raddr       = q_cmd.cell_address[MEM_AW-1:0];
        do_nl           = 1'b0;

        case (state_reg)
            ST_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = clr_reg;
                mem_wdata = BLANK_CELL;
                clr_next  = clr_reg + MEM_AW'(1);
                if (clr_reg == MEM_AW'(CELLS - 1))
                begin
                    state_next = ST_RUN;
                end
            end

            ST_RUN:
            begin
                if (q_valid)
                begin
                    state_next    = ST_REPORT;
                    res_read_next = (q_cmd.cls == CLS_READ);
                    res_upd_next  = 1'b0;
                    res_scr_next  = 1'b0;
                    res_acc_next  = 1'b1;
                    res_oob_next  = q_cmd.cell_address >= ADDR_W'(CELLS);
                    if (q_cmd.cls == CLS_READ)
                    begin
                        mem_re = !res_oob_next;
                    end
                    else if (!in_screen)
                    begin
                        res_acc_next = 1'b0;
                    end
                    else if (q_cmd.cls != CLS_ZERO)
                    begin
                        res_upd_next = cfg.cursor_en;
                        case (q_cmd.cls)
                            CLS_NL:
                            begin
                                do_nl = 1'b1;
                            end
                            CLS_CR:
                            begin
                                col_next = '0;
                            end
                            CLS_TAB:
                            begin
                                if (!cfg.tab[0])
                                begin
                                    if (tab_past)
                                    begin
                                        do_nl = 1'b1;
                                    end
                                    else
                                    begin
                                        col_next = tab_col[COL_W-1:0];
                                    end
                                end
                            end
                            CLS_VT:
                            begin
                                if (row_reg != '0)
                                begin
                                    row_next = row_reg - ROW_W'(1);
                                end
                            end
                            CLS_PRINT:
                            begin
                                mem_we = 1'b1;
                                if (at_end)
                                begin
                                    do_nl = 1'b1;
                                end
                                else
                                begin
                                    col_next = col_reg + COL_W'(1);
                                end
                            end
                            default: ;
                        endcase
                    end

                    if (do_nl)
                    begin
                        col_next = '0;
                        row_next = nl_row;
                        if (nl_scroll)
                        begin
                            res_scr_next    = 1'b1;
                            state_next      = ST_SCROLL;
                            ptr_next        = '0;
                            total_next      = CNT_W'(area);
                            copy_end_next   = CNT_W'(area - {{ROW_W{1'b0}}, nc});
                            pend_valid_next = 1'b0;
                        end
                    end
                end
            end

            // one cell a cycle: read cell p+columns, write it at p on the next cycle;
            // cells of the bottom row get the blank with the current attribute
            ST_SCROLL:
            begin
                if (pend_valid_reg)
                begin
                    mem_we    = 1'b1;
                    mem_waddr = pend_addr_reg;
                    mem_wdata = pend_copy_reg ? rd_data_reg : fill_cell;
                end
                if (ptr_reg < total_reg)
                begin
                    pend_valid_next = 1'b1;
                    pend_addr_next  = ptr_reg[MEM_AW-1:0];
                    pend_copy_next  = ptr_reg < copy_end_reg;
                    mem_re          = pend_copy_next;
                    mem_raddr       = MEM_AW'(ptr_reg + CNT_W'(nc));
                    ptr_next        = ptr_reg + CNT_W'(1);
                end
                else
                begin
                    pend_valid_next = 1'b0;
                    state_next      = ST_REPORT;
                end
            end

            ST_REPORT:
            begin
                if (out_load)
                begin
                    state_next = ST_RUN;
                end
            end

            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLEAR;
            col_reg        <= '0;
            row_reg        <= '0;
            clr_reg        <= '0;
            ptr_reg        <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            col_reg        <= col_next;
            row_reg        <= row_next;
            clr_reg        <= clr_next;
            ptr_reg        <= ptr_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        total_reg     <= total_next;
        copy_end_reg  <= copy_end_next;
        pend_addr_reg <= pend_addr_next;
        pend_copy_reg <= pend_copy_next;
        res_read_reg  <= res_read_next;
        res_upd_reg   <= res_upd_next;
        res_scr_reg   <= res_scr_next;
        res_acc_reg   <= res_acc_next;
        res_oob_reg   <= res_oob_next;
        if (out_load)
        begin
            out_offset_reg <= cur_off[ADDR_W-1:0];
            out_col_reg    <= col_reg;
            out_row_reg    <= row_reg;
            out_upd_reg    <= res_upd_reg;
            out_scr_reg    <= res_scr_reg;
            out_acc_reg    <= res_acc_reg;
            if (res_read_reg && !res_oob_reg)
            begin
                out_char_reg <= rd_data_reg[CHAR_W-1:0];
                out_attr_reg <= rd_data_reg[CELL_W-1:CHAR_W];
            end
            else
            begin
                out_char_reg <= '0;
                out_attr_reg <= '0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rd_data_reg <= mem[mem_raddr];
        end
    end

    assign rsp.valid         = out_valid_reg;
    assign rsp.cursor_offset = out_offset_reg;
    assign rsp.cursor_column = out_col_reg;
    assign rsp.cursor_row    = out_row_reg;
    assign rsp.cursor_update = out_upd_reg;
    assign rsp.scrolled      = out_scr_reg;
    assign rsp.accepted      = out_acc_reg;
    assign rsp.cell_char     = out_char_reg;
    assign rsp.cell_attr     = out_attr_reg;

endmodule

### src/tcce_checker.sv
module tcce_checker (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              rsp_valid,
    input  logic                              rsp_ready,
    input  logic [tcce_pkg::ADDR_W-1:0]       cursor_offset,
    input  logic [tcce_pkg::COL_W-1:0]        cursor_column,
    input  logic [tcce_pkg::ROW_W-1:0]        cursor_row,
    input  logic                              cursor_update,
    input  logic                              scrolled,
    input  logic                              accepted,
    input  logic [tcce_pkg::CHAR_W-1:0]       cell_char,
    input  logic [tcce_pkg::CHAR_W-1:0]       cell_attr
);
    import tcce_pkg::*;

    // a stalled response keeps its contents
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(cursor_offset)
            && $stable(cursor_row) && $stable(cell_char) && $stable(cell_attr))
        else $error("response changed while stalled");

    a_row_range: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> cursor_row < ROW_W'(MAX_ROWS))
        else $error("cursor row beyond store");

    a_ignored_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !accepted |-> !scrolled && !cursor_update)
        else $error("ignored put reported activity");

    a_scroll_col: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && scrolled |-> cursor_column == '0)
        else $error("scroll left cursor off column zero");

    // only a read returns cell data, and a read never moves or scrolls
    a_read_flags: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (cell_char != '0 || cell_attr != '0)
            |-> accepted && !scrolled && !cursor_update)
        else $error("cell data on a put response");

endmodule

bind text_console_character_engine tcce_checker u_tcce_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .rsp_valid     (rsp.valid),
    .rsp_ready     (rsp.ready),
    .cursor_offset (rsp.cursor_offset),
    .cursor_column (rsp.cursor_column),
    .cursor_row    (rsp.cursor_row),
    .cursor_update (rsp.cursor_update),
    .scrolled      (rsp.scrolled),
    .accepted      (rsp.accepted),
    .cell_char     (rsp.cell_char),
    .cell_attr     (rsp.cell_attr)
);
